### hw/rtl/n_queens_backtrack_solver_assert.svh
// Assertion macros shared by the solver RTL.
`ifndef N_QUEENS_BACKTRACK_SOLVER_ASSERT_SVH
`define N_QUEENS_BACKTRACK_SOLVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NQB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nqb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NQB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nqb assertion failed");

`endif

### hw/rtl/nqb_pkg.sv
package nqb_pkg;
	localparam int MAX_SIZE  = 16;
	localparam int FIELD_CAP = 16;
	localparam int SIZE_CAP  = (MAX_SIZE > FIELD_CAP) ? FIELD_CAP : MAX_SIZE;
	localparam int NCELL     = FIELD_CAP;

	localparam logic [1:0] STATUS_ROW      = 2'd0;
	localparam logic [1:0] STATUS_NONE     = 2'd1;
	localparam logic [1:0] STATUS_TOO_MANY = 2'd2;

	// Attack masks handed from one column cell to the next. Bit r is set when
	// row r of the receiving column is attacked along that line.
	typedef struct packed {
		logic [FIELD_CAP-1:0] rows;
		logic [FIELD_CAP-1:0] down;
		logic [FIELD_CAP-1:0] up;
	} nqb_link_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic       place;
		logic [3:0] trial;
		logic [3:0] emit_row;
	} nqb_ctrl_t;
endpackage

### hw/rtl/nqb_cell.sv
module nqb_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sel,
	input  logic              in_use,
	input  nqb_pkg::nqb_ctrl_t ctrl,
	input  nqb_pkg::nqb_link_t link_in,
	output nqb_pkg::nqb_link_t link_out,
	output logic              free,
	output logic              emit_bit,
	output logic [3:0]        row
);
	import nqb_pkg::*;

	logic [FIELD_CAP-1:0] taken;
	logic [FIELD_CAP-1:0] onehot;
	logic [3:0]           row_q;
	nqb_link_t            link_q;

	assign taken    = link_in.rows | link_in.down | link_in.up;
	assign onehot   = FIELD_CAP'(1) << ctrl.trial;
	assign free     = !taken[ctrl.trial];
	assign emit_bit = in_use && (row_q == ctrl.emit_row);
	assign row      = row_q;
	assign link_out = link_q;

	// The queen row is payload; the outgoing masks reset so the chain is clean.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else if (sel && ctrl.place) begin
			link_q.rows <= link_in.rows | onehot;
			link_q.down <= (link_in.down | onehot) << 1;
			link_q.up   <= (link_in.up | onehot) >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (sel && ctrl.place) begin
			row_q <= ctrl.trial;
		end
	end
endmodule

### hw/rtl/n_queens_backtrack_solver.sv
// N-queens solver: each input beat carries a board size and a queen count and starts a
// depth-first search that places one queen per column from column 0, trying rows in
// increasing order. The search runs on a chain of sixteen column cells; each cell keeps
// the row of its own queen and passes the row and diagonal attack masks on to the next
// column. One trial row is tested per clock cycle, and a backtrack step returns to the
// previous column and resumes one row below its queen. An item is taken in, searched by
// trials and backtracks, found complete once the last column is filled, and then sent
// out as result beats, each of which waits while the receiver stalls. When there are more
// queens than rows, no search is run: the item goes straight from the idle state to the
// status state, which loads the status beat. The first solution comes out as one
// beat per board row with a column bitmask and last set on the final row. A count of
// zero queens gives all-zero rows. When no solution exists, or there are more queens
// than rows, a single status beat with last set is returned instead. Board size zero is
// treated as one and sizes above sixteen as sixteen. A new item is taken only when the
// previous search has finished and its final beat is in the output register.
module n_queens_backtrack_solver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  board_size,
	input  logic [4:0]  queen_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [3:0]  row_index,
	output logic [15:0] row_bits,
	output logic        last
);
	import nqb_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT,
		ST_STATUS
	} state_t;

	state_t     state_q;
	logic [4:0] size_q;
	logic [4:0] queens_q;
	logic [4:0] col_q;
	logic [4:0] trial_q;
	logic [3:0] emit_q;
	logic [1:0] code_q;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [3:0]  row_index_q;
	logic [15:0] row_bits_q;
	logic        last_q;

	logic [4:0] size_eff;
	logic       out_load;
	logic       in_accept;

	nqb_ctrl_t        ctrl;
	nqb_link_t        link [NCELL+1];
	logic [3:0]       cell_row [NCELL];
	logic [NCELL-1:0] free_vec;
	logic [NCELL-1:0] emit_vec;

	logic       do_place;
	logic       trial_ok;
	logic       cur_free;
	logic [3:0] prev_col;
	logic       emit_last;

	// Clamp the board size into the range the result fields can carry.
	always_comb begin
		if (board_size == 5'd0) begin
			size_eff = 5'd1;
		end else if (board_size > 5'(SIZE_CAP)) begin
			size_eff = 5'(SIZE_CAP);
		end else begin
			size_eff = board_size;
		end
	end

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_load  = !out_valid_q || !out_stall;

	// The active column is always below sixteen while a trial is being made.
	assign trial_ok  = (trial_q < size_q);
	assign cur_free  = free_vec[col_q[3:0]];
	assign prev_col  = col_q[3:0] - 4'd1;
	assign do_place  = (state_q == ST_SEARCH) && (col_q != queens_q) && trial_ok && cur_free;
	assign emit_last = ({1'b0, emit_q} + 5'd1 == size_q);

	assign ctrl.place    = do_place;
	assign ctrl.trial    = trial_q[3:0];
	assign ctrl.emit_row = emit_q;

	assign link[0] = '0;

	for (genvar c = 0; c < NCELL; c++) begin : g_cell
		nqb_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.sel      (col_q == 5'(c)),
			.in_use   (5'(c) < queens_q),
			.ctrl     (ctrl),
			.link_in  (link[c]),
			.link_out (link[c+1]),
			.free     (free_vec[c]),
			.emit_bit (emit_vec[c]),
			.row      (cell_row[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			trial_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A beat that has been taken leaves the output register unless the
			// emitting states load the next one in its place.
			if (out_load && state_q != ST_EMIT && state_q != ST_STATUS) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						size_q   <= size_eff;
						queens_q <= queen_count;
						col_q    <= '0;
						trial_q  <= '0;
						emit_q   <= '0;
						if (queen_count > size_eff) begin
							code_q  <= STATUS_TOO_MANY;
							state_q <= ST_STATUS;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (col_q == queens_q) begin
						state_q <= ST_EMIT;
					end else if (trial_ok) begin
						if (cur_free) begin
							col_q   <= col_q + 5'd1;
							trial_q <= '0;
						end else begin
							trial_q <= trial_q + 5'd1;
						end
					end else if (col_q == 5'd0) begin
						code_q  <= STATUS_NONE;
						state_q <= ST_STATUS;
					end else begin
						// Backtrack: resume the previous column one row below its queen.
						col_q   <= col_q - 5'd1;
						trial_q <= {1'b0, cell_row[prev_col]} + 5'd1;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						status_q    <= STATUS_ROW;
						row_index_q <= emit_q;
						row_bits_q  <= emit_vec;
						last_q      <= emit_last;
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							emit_q <= emit_q + 4'd1;
						end
					end
				end
				ST_STATUS: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						status_q    <= code_q;
						row_index_q <= '0;
						row_bits_q  <= '0;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign row_index = row_index_q;
	assign row_bits  = row_bits_q;
	assign last      = last_q;

`include "n_queens_backtrack_solver_assert.svh"

	// Queens never share a row, so each result row holds at most one queen.
	`NQB_ASSERT_NOW(a_row_onehot, out_valid && status == STATUS_ROW, $onehot0(row_bits))
	// Status beats carry an empty row and always close the item.
	`NQB_ASSERT_NOW(a_status_shape, out_valid && status != STATUS_ROW,
		last && row_bits == 16'd0 && row_index == 4'd0)
	// The search never runs past the requested queen count.
	`NQB_ASSERT_NOW(a_col_bound, state_q == ST_SEARCH, col_q <= queens_q)
	// Placing a queen always advances to a fresh trial in the next column.
	`NQB_ASSERT_NEXT(a_place_adv, do_place, trial_q == 5'd0 && col_q == $past(col_q) + 5'd1)
endmodule
